// ----- hdl/text_to_integer_any_base_top_defines.svh -----
// Assertion macros shared by the text to integer converter.
`ifndef TEXT_TO_INTEGER_ANY_BASE_TOP_DEFINES_SVH
`define TEXT_TO_INTEGER_ANY_BASE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define T2I_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define T2I_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/t2i_pkg.sv -----
// Shared types and constants of the text to integer converter.
`default_nettype none

package t2i_pkg;

  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int CH_W = 8;
  localparam int DATA_W = 64;
  localparam int IDX_W = 4;
  localparam int BASE_W = 5;
  localparam int PH_W = 3;
  localparam int AL_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [BASE_W-1:0] FULL_BASE = 5'd16;

  localparam logic [PH_W-1:0] PH_LEAD = 3'd0;
  localparam logic [PH_W-1:0] PH_ZERO = 3'd1;
  localparam logic [PH_W-1:0] PH_HEX0 = 3'd2;
  localparam logic [PH_W-1:0] PH_HEXZ = 3'd3;
  localparam logic [PH_W-1:0] PH_DIG = 3'd4;

  localparam logic [AL_W-1:0] AL_DEC = 2'd0;
  localparam logic [AL_W-1:0] AL_HEXL = 2'd1;
  localparam logic [AL_W-1:0] AL_HEXU = 2'd2;
  localparam logic [AL_W-1:0] AL_BIN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd3;

  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_PLUS = 8'h2b;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB = 8'h09;
  localparam logic [CH_W-1:0] CH_CR = 8'h0d;
  localparam logic [CH_W-1:0] CH_0 = 8'h30;
  localparam logic [CH_W-1:0] CH_1 = 8'h31;
  localparam logic [CH_W-1:0] CH_9 = 8'h39;
  localparam logic [CH_W-1:0] CH_LA = 8'h61;
  localparam logic [CH_W-1:0] CH_LF = 8'h66;
  localparam logic [CH_W-1:0] CH_UA = 8'h41;
  localparam logic [CH_W-1:0] CH_UF = 8'h46;
  localparam logic [CH_W-1:0] CH_LX = 8'h78;
  localparam logic [CH_W-1:0] CH_UX = 8'h58;
  localparam logic [CH_W-1:0] CH_LB = 8'h62;

  typedef struct packed {
    logic ok;
    logic full16;
  } alpha_cfg_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic hit_a;
    logic [IDX_W-1:0] idx_a;
    logic hit_b;
    logic [IDX_W-1:0] idx_b;
  } digit_info_t;

endpackage

`default_nettype wire

// ----- hdl/t2i_alpha.sv -----
// Alphabet decoder: configured alphabet checks, base and digit lookup of two characters.
`default_nettype none

module t2i_alpha #(
  parameter int MAX_SYMBOLS = t2i_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                                mode,
  input  logic [t2i_pkg::BASE_W-1:0]          length,
  input  logic [t2i_pkg::DATA_W-1:0]          low_word,
  input  logic [t2i_pkg::DATA_W-1:0]          high_word,
  input  logic [t2i_pkg::AL_W-1:0]            alph,
  input  logic [t2i_pkg::CH_W-1:0]            char_a,
  input  logic [t2i_pkg::CH_W-1:0]            char_b,
  output t2i_pkg::alpha_cfg_t                 cfg_info,
  output t2i_pkg::digit_info_t                dig_info
);

  localparam int SYM_W = t2i_pkg::CH_W;
  localparam int BW = t2i_pkg::BASE_W;
  localparam int IW = t2i_pkg::IDX_W;
  localparam logic [BW-1:0] MAX_N = BW'(MAX_SYMBOLS);

  logic [2*t2i_pkg::DATA_W-1:0] word;
  logic [BW-1:0] len_sat;
  logic [BW-1:0] count;
  logic dup;
  logic [IW:0] cust_a;
  logic [IW:0] cust_b;
  logic [IW:0] auto_a;
  logic [IW:0] auto_b;
  logic [BW-1:0] auto_base;

  function automatic logic [IW:0] custom_find(input logic [SYM_W-1:0] ch,
                                              input logic [BW-1:0] n,
                                              input logic [2*t2i_pkg::DATA_W-1:0] w);
    logic [IW:0] r;
    r = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if (BW'(i) < n && w[SYM_W*i +: SYM_W] == ch) begin
        r = {1'b1, IW'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic [IW:0] auto_find(input logic [t2i_pkg::AL_W-1:0] al,
                                            input logic [SYM_W-1:0] ch);
    logic hit;
    logic [SYM_W-1:0] d;
    hit = 1'b0;
    d = '0;
    if (al == t2i_pkg::AL_BIN) begin
      if (ch == t2i_pkg::CH_0 || ch == t2i_pkg::CH_1) begin
        hit = 1'b1;
        d = ch - t2i_pkg::CH_0;
      end
    end else if (ch inside {[t2i_pkg::CH_0:t2i_pkg::CH_9]}) begin
      hit = 1'b1;
      d = ch - t2i_pkg::CH_0;
    end else if (al == t2i_pkg::AL_HEXL && (ch inside {[t2i_pkg::CH_LA:t2i_pkg::CH_LF]})) begin
      hit = 1'b1;
      d = ch - t2i_pkg::CH_LA + 8'd10;
    end else if (al == t2i_pkg::AL_HEXU && (ch inside {[t2i_pkg::CH_UA:t2i_pkg::CH_UF]})) begin
      hit = 1'b1;
      d = ch - t2i_pkg::CH_UA + 8'd10;
    end
    return {hit, d[IW-1:0]};
  endfunction

  assign word = {high_word, low_word};
  assign len_sat = (length > MAX_N) ? MAX_N : length;

  // The alphabet ends at the first zero symbol.
  always_comb begin
    count = len_sat;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if (BW'(i) < len_sat && word[SYM_W*i +: SYM_W] == '0) begin
        count = BW'(i);
      end
    end
  end

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
        if (BW'(j) < count && word[SYM_W*i +: SYM_W] == word[SYM_W*j +: SYM_W]) begin
          dup = 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (alph)
      t2i_pkg::AL_HEXL, t2i_pkg::AL_HEXU: auto_base = t2i_pkg::FULL_BASE;
      t2i_pkg::AL_BIN: auto_base = 5'd2;
      default: auto_base = 5'd10;
    endcase
  end

  assign cust_a = custom_find(char_a, count, word);
  assign cust_b = custom_find(char_b, count, word);
  assign auto_a = auto_find(alph, char_a);
  assign auto_b = auto_find(alph, char_b);

  assign cfg_info.ok = (count >= 5'd2) && !dup;
  assign cfg_info.full16 = (count == t2i_pkg::FULL_BASE);

  always_comb begin
    if (mode) begin
      dig_info.base = count;
      {dig_info.hit_a, dig_info.idx_a} = cust_a;
      {dig_info.hit_b, dig_info.idx_b} = cust_b;
    end else begin
      dig_info.base = auto_base;
      {dig_info.hit_a, dig_info.idx_a} = auto_a;
      {dig_info.hit_b, dig_info.idx_b} = auto_b;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/text_to_integer_any_base_top.sv -----
// Top level of the streaming text to signed 64-bit integer converter.
// The block takes one character per cycle and returns one result for each string; the
// result register is written at the edge at which the final character leaves the input register.
// A character first lands in an input register; the next cycle decodes the prefix and sign
// phase, looks the character up in the active alphabet with parallel comparators, and does
// one 64-bit by 5-bit multiply-add into the accumulator, writing the result register when
// the character is final. Characters that are not final never wait on the output side; a
// final character waits in the input register only while the result register holds an
// untaken result.
`default_nettype none
`include "text_to_integer_any_base_top_defines.svh"

module text_to_integer_any_base_top #(
  parameter int MAX_SYMBOLS = t2i_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [t2i_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [t2i_pkg::DATA_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [t2i_pkg::CH_W-1:0]           character,
  input  logic                               is_final,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [t2i_pkg::DATA_W-1:0]  value,
  output logic                               alphabet_ok
);

  localparam int DW = t2i_pkg::DATA_W;

  logic mode;
  logic [t2i_pkg::BASE_W-1:0] length;
  logic [DW-1:0] low_word;
  logic [DW-1:0] high_word;

  logic q_valid;
  logic [t2i_pkg::CH_W-1:0] q_char;
  logic q_final;

  logic [t2i_pkg::PH_W-1:0] phase;
  logic [t2i_pkg::CH_W-1:0] held;
  logic [DW-1:0] acc;
  logic neg;
  logic [t2i_pkg::AL_W-1:0] alph;
  logic stopped;

  logic adv;
  logic [t2i_pkg::PH_W-1:0] phase_next;
  logic [t2i_pkg::CH_W-1:0] held_next;
  logic neg_next;
  logic [t2i_pkg::AL_W-1:0] alph_next;
  logic use_held;
  logic use_char;
  logic [DW-1:0] acc_a;
  logic stop_a;
  logic [DW-1:0] acc_next;
  logic stopped_next;
  logic [DW-1:0] signed_acc;
  logic ok_now;

  t2i_pkg::alpha_cfg_t cfg_info;
  t2i_pkg::digit_info_t dig_info;

  t2i_alpha #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_alpha (
    .mode(mode),
    .length(length),
    .low_word(low_word),
    .high_word(high_word),
    .alph(alph_next),
    .char_a(held_next),
    .char_b(q_char),
    .cfg_info(cfg_info),
    .dig_info(dig_info)
  );

  assign adv = q_valid && (!q_final || !out_valid || out_ready);
  assign in_ready = !q_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      length <= 5'd10;
      low_word <= '0;
      high_word <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        t2i_pkg::REG_MODE: mode <= cfg_data[0];
        t2i_pkg::REG_LENGTH: length <= cfg_data[t2i_pkg::BASE_W-1:0];
        t2i_pkg::REG_LOW: low_word <= cfg_data;
        t2i_pkg::REG_HIGH: high_word <= cfg_data;
        default: mode <= mode;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    held_next = held;
    neg_next = neg;
    alph_next = alph;
    use_held = 1'b0;
    use_char = 1'b0;
    case (phase)
      t2i_pkg::PH_LEAD: begin
        if (q_char == t2i_pkg::CH_MINUS) begin
          neg_next = ~neg;
        end else if (q_char == t2i_pkg::CH_PLUS || q_char == t2i_pkg::CH_SPACE ||
                     (q_char inside {[t2i_pkg::CH_TAB:t2i_pkg::CH_CR]})) begin
          phase_next = phase;
        end else if (!mode) begin
          if (q_char == t2i_pkg::CH_0) begin
            held_next = q_char;
            phase_next = t2i_pkg::PH_ZERO;
          end else begin
            alph_next = t2i_pkg::AL_DEC;
            phase_next = t2i_pkg::PH_DIG;
            use_char = 1'b1;
          end
        end else if (cfg_info.ok && cfg_info.full16 && q_char == t2i_pkg::CH_0) begin
          held_next = q_char;
          phase_next = t2i_pkg::PH_HEXZ;
        end else begin
          phase_next = t2i_pkg::PH_DIG;
          use_char = 1'b1;
        end
      end
      t2i_pkg::PH_ZERO: begin
        if (q_char == t2i_pkg::CH_LX) begin
          alph_next = t2i_pkg::AL_HEXL;
          phase_next = t2i_pkg::PH_HEX0;
        end else if (q_char == t2i_pkg::CH_UX) begin
          alph_next = t2i_pkg::AL_HEXU;
          phase_next = t2i_pkg::PH_HEX0;
        end else if (q_char == t2i_pkg::CH_LB) begin
          alph_next = t2i_pkg::AL_BIN;
          phase_next = t2i_pkg::PH_DIG;
        end else begin
          alph_next = t2i_pkg::AL_DEC;
          phase_next = t2i_pkg::PH_DIG;
          use_held = 1'b1;
          use_char = 1'b1;
        end
      end
      t2i_pkg::PH_HEX0: begin
        if (q_char == t2i_pkg::CH_0) begin
          held_next = q_char;
          phase_next = t2i_pkg::PH_HEXZ;
        end else begin
          phase_next = t2i_pkg::PH_DIG;
          use_char = 1'b1;
        end
      end
      t2i_pkg::PH_HEXZ: begin
        phase_next = t2i_pkg::PH_DIG;
        if (q_char != t2i_pkg::CH_LX && q_char != t2i_pkg::CH_UX) begin
          use_held = 1'b1;
          use_char = 1'b1;
        end
      end
      default: begin
        use_char = 1'b1;
      end
    endcase
    // A zero still held at the end of the string counts as a digit.
    if (q_final && phase_next == t2i_pkg::PH_ZERO) begin
      alph_next = t2i_pkg::AL_DEC;
      use_held = 1'b1;
    end else if (q_final && phase_next == t2i_pkg::PH_HEXZ) begin
      use_held = 1'b1;
    end
  end

  // A held zero is only ever taken before any digit, so the accumulator is still zero then.
  always_comb begin
    acc_a = acc;
    stop_a = stopped;
    if (use_held && !stopped) begin
      if (dig_info.hit_a) begin
        acc_a = DW'(dig_info.idx_a);
      end else begin
        stop_a = 1'b1;
      end
    end
    acc_next = acc_a;
    stopped_next = stop_a;
    if (use_char && !stop_a) begin
      if (dig_info.hit_b) begin
        acc_next = acc_a * DW'(dig_info.base) + DW'(dig_info.idx_b);
      end else begin
        stopped_next = 1'b1;
      end
    end
  end

  assign signed_acc = neg_next ? (DW'(0) - acc_next) : acc_next;
  assign ok_now = !mode || cfg_info.ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (adv) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_char <= character;
      q_final <= is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= t2i_pkg::PH_LEAD;
      held <= '0;
      acc <= '0;
      neg <= 1'b0;
      alph <= t2i_pkg::AL_DEC;
      stopped <= 1'b0;
    end else if (adv) begin
      if (q_final) begin
        phase <= t2i_pkg::PH_LEAD;
        held <= '0;
        acc <= '0;
        neg <= 1'b0;
        alph <= t2i_pkg::AL_DEC;
        stopped <= 1'b0;
      end else begin
        phase <= phase_next;
        held <= held_next;
        acc <= acc_next;
        neg <= neg_next;
        alph <= alph_next;
        stopped <= stopped_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && q_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && q_final) begin
      value <= ok_now ? signed_acc : '0;
      alphabet_ok <= ok_now;
    end
  end

  `T2I_ASSERT_NOW(a_stall_only_when_full, clk, rst, q_valid && !adv, q_final && out_valid && !out_ready, "input register stalled without a blocked result")

  `T2I_ASSERT_NEXT(a_final_gives_result, clk, rst, adv && q_final, out_valid, "final character did not produce a result")

  `T2I_ASSERT_NEXT(a_final_clears_state, clk, rst, adv && q_final, phase == t2i_pkg::PH_LEAD && acc == '0 && !neg && !stopped, "parse state not cleared after a string")

endmodule

`default_nettype wire
